// File: src/nvlc_pkg.sv
// Shared types, byte codes and helpers for the name/value line checker.
`timescale 1ns / 1ps
`default_nettype none

package nvlc_pkg;

    // Byte codes the parser looks for
    localparam logic [7:0] CH_NUL   = 8'd0;
    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_QUOTE = 8'd34;
    localparam logic [7:0] CH_POUND = 8'd35;
    localparam logic [7:0] CH_EQ    = 8'd61;

    // Role tags given for each byte
    localparam logic [1:0] ROLE_STRUCT = 2'd0;
    localparam logic [1:0] ROLE_NAME   = 2'd1;
    localparam logic [1:0] ROLE_VALUE  = 2'd2;

    // Position within the current line
    typedef enum logic [3:0] {
        PH_LEAD      = 4'd0,
        PH_NAME      = 4'd1,
        PH_NAME_WS   = 4'd2,
        PH_EQ_WS     = 4'd3,
        PH_BARE      = 4'd4,
        PH_QUOTED    = 4'd5,
        PH_TAIL_WS   = 4'd6,
        PH_GOOD_REST = 4'd7,
        PH_BAD_REST  = 4'd8
    } nvlc_phase_t;

    // One result item
    typedef struct packed {
        logic [1:0] byte_role;
        logic       line_done;
        logic       line_ok;
    } nvlc_result_t;

    // Space or tab
    function automatic logic is_ws(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB);
    endfunction

    // Verdict if the line's content ended in this phase
    function automatic logic phase_ok(input nvlc_phase_t p);
        return (p == PH_EQ_WS) || (p == PH_BARE) || (p == PH_TAIL_WS) ||
               (p == PH_GOOD_REST);
    endfunction

endpackage

`default_nettype wire

// File: src/name_value_line_checker.sv
// Top level: input register, parse stage and result register.
// Each byte passes through the input register and then the result register; a stalled result holds it.
// Throughput: one byte per cycle while result_stall is low, set by the phase update loop.
// The input register takes a new item while a result waits to be taken, if it is empty.
// Reset: asynchronous, active low; clears both stage valids and returns the
// line phase to the leading whitespace phase.
`timescale 1ns / 1ps
`default_nettype none

module name_value_line_checker
    import nvlc_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       item_valid,
    output logic            item_stall,
    input  wire logic [7:0] text_byte,
    input  wire logic       buffer_end,
    output logic            result_valid,
    input  wire logic       result_stall,
    output logic [1:0]      byte_role,
    output logic            line_done,
    output logic            line_ok
);

    logic         hold_valid_reg;
    logic [7:0]   hold_byte_reg;
    logic         hold_end_reg;
    logic         out_valid_reg;
    nvlc_result_t out_reg;
    nvlc_result_t parse_result;
    logic         advance;
    logic         take_in;

    // Move the held item on when the result register is free or draining
    assign advance    = hold_valid_reg & (~out_valid_reg | ~result_stall);
    assign item_stall = hold_valid_reg & ~advance;
    assign take_in    = item_valid & ~item_stall;

    nvlc_parse u_parse (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (advance),
        .text_byte  (hold_byte_reg),
        .buffer_end (hold_end_reg),
        .result     (parse_result)
    );

    // Hold the accepted item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hold_valid_reg <= 1'b0;
        else if (take_in)
            hold_valid_reg <= 1'b1;
        else if (advance)
            hold_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (take_in)
        begin
            hold_byte_reg <= text_byte;
            hold_end_reg  <= buffer_end;
        end
    end

    // Register the result item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (!result_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            out_reg <= parse_result;
    end

    assign result_valid = out_valid_reg;
    assign byte_role    = out_reg.byte_role;
    assign line_done    = out_reg.line_done;
    assign line_ok      = out_reg.line_ok;

endmodule

`default_nettype wire

// File: src/nvlc_parse.sv
// Line phase register and per-byte parse logic.
`timescale 1ns / 1ps
`default_nettype none

module nvlc_parse
    import nvlc_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         step,
    input  wire logic [7:0]   text_byte,
    input  wire logic         buffer_end,
    output nvlc_result_t      result
);

    nvlc_phase_t phase_reg;
    nvlc_phase_t phase_next;
    nvlc_phase_t content_phase;
    logic [1:0]  role;
    logic        done;
    logic        ok;

    // Work out the role, the verdict and the next phase for this byte
    always_comb
    begin
        content_phase = phase_reg;
        role          = ROLE_STRUCT;
        done          = 1'b0;
        ok            = 1'b0;
        if (text_byte == CH_LF)
        begin
            done = 1'b1;
            ok   = phase_ok(phase_reg);
        end
        else
        begin
            if (text_byte == CH_NUL && phase_reg != PH_GOOD_REST &&
                phase_reg != PH_BAD_REST)
            begin
                // NUL ends the content: judge the line here
                content_phase = phase_ok(phase_reg) ? PH_GOOD_REST : PH_BAD_REST;
            end
            else
            begin
                unique case (phase_reg)
                    PH_LEAD:
                    begin
                        priority if (is_ws(text_byte))
                            content_phase = PH_LEAD;
                        else if (text_byte == CH_EQ || text_byte == CH_POUND)
                            content_phase = PH_BAD_REST;
                        else
                        begin
                            content_phase = PH_NAME;
                            role          = ROLE_NAME;
                        end
                    end
                    PH_NAME:
                    begin
                        priority if (is_ws(text_byte))
                            content_phase = PH_NAME_WS;
                        else if (text_byte == CH_EQ)
                            content_phase = PH_EQ_WS;
                        else if (text_byte == CH_POUND)
                            content_phase = PH_BAD_REST;
                        else
                            role = ROLE_NAME;
                    end
                    PH_NAME_WS:
                    begin
                        priority if (is_ws(text_byte))
                            content_phase = PH_NAME_WS;
                        else if (text_byte == CH_EQ)
                            content_phase = PH_EQ_WS;
                        else
                            content_phase = PH_BAD_REST;
                    end
                    PH_EQ_WS:
                    begin
                        priority if (is_ws(text_byte))
                            content_phase = PH_EQ_WS;
                        else if (text_byte == CH_QUOTE)
                            content_phase = PH_QUOTED;
                        else if (text_byte == CH_POUND)
                            content_phase = PH_GOOD_REST;
                        else
                        begin
                            content_phase = PH_BARE;
                            role          = ROLE_VALUE;
                        end
                    end
                    PH_BARE:
                    begin
                        priority if (is_ws(text_byte))
                            content_phase = PH_TAIL_WS;
                        else if (text_byte == CH_POUND)
                            content_phase = PH_GOOD_REST;
                        else
                            role = ROLE_VALUE;
                    end
                    PH_QUOTED:
                    begin
                        if (text_byte == CH_QUOTE)
                            content_phase = PH_TAIL_WS;
                        else
                            role = ROLE_VALUE;
                    end
                    PH_TAIL_WS:
                    begin
                        priority if (is_ws(text_byte))
                            content_phase = PH_TAIL_WS;
                        else if (text_byte == CH_POUND)
                            content_phase = PH_GOOD_REST;
                        else
                            content_phase = PH_BAD_REST;
                    end
                    PH_GOOD_REST:
                        content_phase = PH_GOOD_REST;
                    default:
                        content_phase = PH_BAD_REST;
                endcase
            end
            // Buffer end closes the line after its byte
            if (buffer_end)
            begin
                done = 1'b1;
                ok   = phase_ok(content_phase);
            end
        end
        phase_next = done ? PH_LEAD : content_phase;
    end

    assign result.byte_role = role;
    assign result.line_done = done;
    assign result.line_ok   = done & ok;

    // Advance the phase once per item taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            phase_reg <= PH_LEAD;
        else if (step)
            phase_reg <= phase_next;
    end

endmodule

`default_nettype wire
